@@ hdl/mandelbrot_escape_pixel_defines.svh @@
// Assertion macros for the Mandelbrot escape-time pixel block.
`ifndef MANDELBROT_ESCAPE_PIXEL_DEFINES_SVH
`define MANDELBROT_ESCAPE_PIXEL_DEFINES_SVH
`ifndef SYNTHESIS
`define MEP_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mep: assertion failed");
`define MEP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mep: assertion failed");
`else
`define MEP_ASSERT(label, clk, rst_n, ante, cons)
`define MEP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hdl/mep_pkg.sv @@
`timescale 1ns / 1ps
// Package: constants, types and fixed-point helpers of the Mandelbrot pixel block.
package mep_pkg;

    localparam int FRAC_BITS = 28;
    localparam int ZW = FRAC_BITS + 4;
    localparam int COORD_BITS = 12;
    localparam int STEP_W = 31;
    localparam int CFG_W = 32;
    localparam int LIMIT_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int COLOR_W = 8;
    localparam int VALUE_W = 2 * COLOR_W;
    localparam int COLOR_SCALE = 1 << VALUE_W;
    localparam int ITER_BITS_DEF = 16;
    localparam int COLOR_DIVISOR_DEF = 1000;
    localparam int QUEUE_DEPTH = 2;
    localparam int SQ_W = 2 * ZW - 1 - FRAC_BITS;
    localparam int CPROD_W = COORD_BITS + STEP_W;
    localparam int SUM_W = ((CPROD_W > SQ_W) ? CPROD_W : SQ_W) + 2;
    localparam int IN_TDATA_W = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 3 * COLOR_W;

    localparam logic [CFG_W-1:0] RST_REGION_LEFT = 32'hE000_0000;
    localparam logic [CFG_W-1:0] RST_REGION_TOP = 32'hF000_0000;
    localparam logic [STEP_W-1:0] RST_STEP_REAL = 31'd745654;
    localparam logic [STEP_W-1:0] RST_STEP_IMAG = 31'd745654;
    localparam logic [LIMIT_W-1:0] RST_ITER_LIMIT = 16'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REGION_LEFT = 3'd0,
        CFG_REGION_TOP  = 3'd1,
        CFG_STEP_REAL   = 3'd2,
        CFG_STEP_IMAG   = 3'd3,
        CFG_ITER_LIMIT  = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic signed [CFG_W-1:0] region_left;
        logic signed [CFG_W-1:0] region_top;
        logic [STEP_W-1:0]       step_real;
        logic [STEP_W-1:0]       step_imag;
        logic [LIMIT_W-1:0]      iteration_limit;
    } t_cfg;

    typedef struct packed {
        logic signed [ZW-1:0] c_re;
        logic signed [ZW-1:0] c_im;
    } t_point;

    typedef struct packed {
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
    } t_rgb;

    function automatic logic signed [ZW-1:0] sat_z(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi_lim;
        logic signed [SUM_W-1:0] lo_lim;
        logic signed [ZW-1:0]    res;
        hi_lim = {{(SUM_W-ZW+1){1'b0}}, {(ZW-1){1'b1}}};
        lo_lim = {{(SUM_W-ZW+1){1'b1}}, {(ZW-1){1'b0}}};
        if (v > hi_lim) begin
            res = {1'b0, {(ZW-1){1'b1}}};
        end else if (v < lo_lim) begin
            res = {1'b1, {(ZW-1){1'b0}}};
        end else begin
            res = v[ZW-1:0];
        end
        return res;
    endfunction

    function automatic logic [ZW-1:0] mag_z(input logic signed [ZW-1:0] v);
        logic [ZW-1:0] u;
        u = v;
        return u[ZW-1] ? (~u + {{(ZW-1){1'b0}}, 1'b1}) : u;
    endfunction

endpackage

@@ hdl/mep_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts pixel requests and maps them to the point c in fixed point.
module mep_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [mep_pkg::COORD_BITS-1:0]    i_pixel_x,
    input  logic [mep_pkg::COORD_BITS-1:0]    i_pixel_y,
    input  mep_pkg::t_cfg                     i_cfg,
    output logic                              o_valid,
    input  logic                              i_ready,
    output mep_pkg::t_point                   o_point
);

    localparam int SUM_W = mep_pkg::SUM_W;
    localparam int CPROD_W = mep_pkg::CPROD_W;
    localparam int CFG_W = mep_pkg::CFG_W;

    logic                     r_valid;
    logic [CPROD_W-1:0]       r_prod_x;
    logic [CPROD_W-1:0]       r_prod_y;
    logic signed [SUM_W-1:0]  sum_re;
    logic signed [SUM_W-1:0]  sum_im;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_prod_x <= CPROD_W'(i_pixel_x) * CPROD_W'(i_cfg.step_real);
            r_prod_y <= CPROD_W'(i_pixel_y) * CPROD_W'(i_cfg.step_imag);
        end
    end

    assign sum_re = $signed({{(SUM_W-CFG_W){i_cfg.region_left[CFG_W-1]}}, i_cfg.region_left})
                  + $signed({{(SUM_W-CPROD_W){1'b0}}, r_prod_x});
    assign sum_im = $signed({{(SUM_W-CFG_W){i_cfg.region_top[CFG_W-1]}}, i_cfg.region_top})
                  + $signed({{(SUM_W-CPROD_W){1'b0}}, r_prod_y});

    assign o_point.c_re = mep_pkg::sat_z(sum_re);
    assign o_point.c_im = mep_pkg::sat_z(sum_im);

endmodule

@@ hdl/mep_queue.sv @@
`timescale 1ns / 1ps
// Short queue of mapped points between the front end and the iteration unit.
`include "mandelbrot_escape_pixel_defines.svh"
module mep_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  mep_pkg::t_point  i_point,
    output logic             o_valid,
    input  logic             i_ready,
    output mep_pkg::t_point  o_point
);

    localparam int DEPTH = mep_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [PTR_W-1:0] PTR_ONE = {{(PTR_W-1){1'b0}}, 1'b1};
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE = {{(CNT_W-1){1'b0}}, 1'b1};

    mep_pkg::t_point   r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              push;
    logic              pop;

    assign o_ready = (r_count != CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_point = r_mem[r_rd_ptr];
    assign push = i_valid && o_ready;
    assign pop = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_ONE;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_ONE;
            end
            if (push && !pop) begin
                r_count <= r_count + CNT_ONE;
            end else if (pop && !push) begin
                r_count <= r_count - CNT_ONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_point;
        end
    end

    `MEP_ASSERT(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_FULL)
    `MEP_ASSERT_NEXT(a_count_step, i_clk, i_rst_n, push && !pop, r_count == $past(r_count) + CNT_ONE)

endmodule

@@ hdl/mep_iter.sv @@
`timescale 1ns / 1ps
// Iteration unit: runs z = z*z + c for one point and colors the escape count.
`include "mandelbrot_escape_pixel_defines.svh"
module mep_iter #(
    parameter int ITER_BITS = mep_pkg::ITER_BITS_DEF,
    parameter int COLOR_DIVISOR = mep_pkg::COLOR_DIVISOR_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  mep_pkg::t_point               i_point,
    input  logic [mep_pkg::LIMIT_W-1:0]   i_limit,
    output logic                          o_valid,
    input  logic                          i_ready,
    output mep_pkg::t_rgb                 o_rgb
);

    localparam int ZW = mep_pkg::ZW;
    localparam int SQ_W = mep_pkg::SQ_W;
    localparam int SUM_W = mep_pkg::SUM_W;
    localparam int FRAC_BITS = mep_pkg::FRAC_BITS;
    localparam int VALUE_W = mep_pkg::VALUE_W;
    localparam int COLOR_W = mep_pkg::COLOR_W;
    localparam int REM_W = $clog2(COLOR_DIVISOR) + 1;
    localparam int Q_INC_I = (mep_pkg::COLOR_SCALE / COLOR_DIVISOR) % mep_pkg::COLOR_SCALE;
    localparam int R_INC_I = mep_pkg::COLOR_SCALE % COLOR_DIVISOR;
    localparam logic [VALUE_W-1:0] Q_INC = VALUE_W'(Q_INC_I);
    localparam logic [VALUE_W-1:0] Q_ONE = {{(VALUE_W-1){1'b0}}, 1'b1};
    localparam logic [REM_W-1:0] R_INC = REM_W'(R_INC_I);
    localparam logic [REM_W-1:0] DIV = REM_W'(COLOR_DIVISOR);
    localparam logic [ITER_BITS-1:0] ITER_ONE = {{(ITER_BITS-1){1'b0}}, 1'b1};
    localparam logic [SQ_W:0] FOUR = {{(SQ_W-FRAC_BITS-2){1'b0}}, 3'b100, {FRAC_BITS{1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MUL  = 3'b010,
        S_UPD  = 3'b100
    } t_iter_state;

    t_iter_state              r_state;
    t_iter_state              n_state;
    logic                     r_out_valid;
    logic                     n_out_valid;
    mep_pkg::t_rgb            r_rgb;
    mep_pkg::t_rgb            n_rgb;
    mep_pkg::t_point          r_c;
    logic signed [ZW-1:0]     r_re;
    logic signed [ZW-1:0]     r_im;
    logic [ITER_BITS-1:0]     r_iter;
    logic [VALUE_W-1:0]       r_q;
    logic [REM_W-1:0]         r_rem;
    logic [SQ_W-1:0]          r_sq_re;
    logic [SQ_W-1:0]          r_sq_im;
    logic [SQ_W-1:0]          r_p_mag;
    logic                     r_p_neg;

    logic [ITER_BITS-1:0]     limit;
    logic [ZW-1:0]            mag_re;
    logic [ZW-1:0]            mag_im;
    logic [2*ZW-1:0]          prod_rr;
    logic [2*ZW-1:0]          prod_ii;
    logic [2*ZW-1:0]          prod_ri;
    logic [SQ_W:0]            esc_sum;
    logic                     still_in;
    logic                     run;
    logic                     out_free;
    logic                     load_out;
    logic signed [SUM_W-1:0]  re_sum;
    logic signed [SUM_W-1:0]  p_ext;
    logic signed [SUM_W-1:0]  p_val;
    logic signed [ZW-1:0]     p_sat;
    logic signed [SUM_W-1:0]  im_sum;
    logic signed [ZW-1:0]     n_re;
    logic signed [ZW-1:0]     n_im;
    logic [REM_W-1:0]         rem_sum;
    logic                     rem_wrap;

    assign limit = ITER_BITS'(i_limit);
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign o_rgb = r_rgb;
    assign out_free = !r_out_valid || i_ready;

    assign mag_re = mep_pkg::mag_z(r_re);
    assign mag_im = mep_pkg::mag_z(r_im);
    assign prod_rr = (2*ZW)'(mag_re) * (2*ZW)'(mag_re);
    assign prod_ii = (2*ZW)'(mag_im) * (2*ZW)'(mag_im);
    assign prod_ri = (2*ZW)'(mag_re) * (2*ZW)'(mag_im);

    assign esc_sum = {1'b0, r_sq_re} + {1'b0, r_sq_im};
    assign still_in = (esc_sum < FOUR);
    assign run = still_in && (r_iter < limit);

    assign re_sum = $signed({{(SUM_W-SQ_W){1'b0}}, r_sq_re})
                  - $signed({{(SUM_W-SQ_W){1'b0}}, r_sq_im})
                  + $signed({{(SUM_W-ZW){r_c.c_re[ZW-1]}}, r_c.c_re});
    assign p_ext = $signed({{(SUM_W-SQ_W){1'b0}}, r_p_mag});
    assign p_val = r_p_neg ? -p_ext : p_ext;
    assign p_sat = mep_pkg::sat_z(p_val);
    assign im_sum = $signed({{(SUM_W-ZW-1){p_sat[ZW-1]}}, p_sat, 1'b0})
                  + $signed({{(SUM_W-ZW){r_c.c_im[ZW-1]}}, r_c.c_im});
    assign n_re = mep_pkg::sat_z(re_sum);
    assign n_im = mep_pkg::sat_z(im_sum);

    assign rem_sum = r_rem + R_INC;
    assign rem_wrap = (rem_sum >= DIV);

    always_comb begin
        n_state = r_state;
        load_out = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (run) begin
                    n_state = S_MUL;
                end else if (out_free) begin
                    n_state = S_IDLE;
                    load_out = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = load_out || (r_out_valid && !i_ready);
        if (still_in) begin
            n_rgb = '0;
        end else begin
            n_rgb.red = r_q[COLOR_W-1:0];
            n_rgb.green = r_q[VALUE_W-1:COLOR_W];
            n_rgb.blue = {COLOR_W{1'b1}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    r_c <= i_point;
                    r_re <= '0;
                    r_im <= '0;
                    r_iter <= '0;
                    r_q <= '0;
                    r_rem <= '0;
                end
            end
            S_MUL: begin
                r_sq_re <= prod_rr[FRAC_BITS +: SQ_W];
                r_sq_im <= prod_ii[FRAC_BITS +: SQ_W];
                r_p_mag <= prod_ri[FRAC_BITS +: SQ_W];
                r_p_neg <= r_re[ZW-1] ^ r_im[ZW-1];
            end
            S_UPD: begin
                if (run) begin
                    r_re <= n_re;
                    r_im <= n_im;
                    r_iter <= r_iter + ITER_ONE;
                    r_q <= r_q + Q_INC + (rem_wrap ? Q_ONE : '0);
                    r_rem <= rem_wrap ? (rem_sum - DIV) : rem_sum;
                end
            end
            default: begin
            end
        endcase
        if (load_out) begin
            r_rgb <= n_rgb;
        end
    end

    `MEP_ASSERT_NEXT(a_iter_step, i_clk, i_rst_n, (r_state == S_UPD) && run, r_iter == $past(r_iter) + ITER_ONE)
    `MEP_ASSERT(a_out_from_upd, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state == S_UPD))
    `MEP_ASSERT(a_black_inside, i_clk, i_rst_n, r_out_valid && (r_rgb.blue == '0), (r_rgb.red == '0) && (r_rgb.green == '0))

endmodule

@@ hdl/mandelbrot_escape_pixel.sv @@
`timescale 1ns / 1ps
// Top level: Mandelbrot escape-time pixel colorer with front end, queue and iteration unit.
//
//  channel   direction  handshake                       payload
//  s_axis    in         s_axis_tvalid / s_axis_tready   pixel_x, pixel_y
//  m_axis    out        m_axis_tvalid / m_axis_tready   red, green, blue
//  cfg       in         i_cfg_we                        i_cfg_idx, i_cfg_data
//
// Each pixel in the iteration unit runs n iterations, n from 0 to iteration_limit;
// each iteration is a multiply state on three 32x32 multipliers and an
// add/saturate/escape-test state. The front end registers its products ahead
// of the queue.
// Reset is synchronous, active low; it clears handshake state and loads register defaults.
// The front end and a two-entry queue keep taking requests while a pixel iterates;
// a finished pixel waits in the output register and the unit holds until it is taken.
module mandelbrot_escape_pixel #(
    parameter int ITER_BITS = mep_pkg::ITER_BITS_DEF,
    parameter int COLOR_DIVISOR = mep_pkg::COLOR_DIVISOR_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // pixel_x [11:0], pixel_y [23:12]
    input  logic [mep_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // red [7:0], green [15:8], blue [23:16]
    output logic [mep_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                               i_cfg_we,
    input  logic [mep_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [mep_pkg::CFG_W-1:0]          i_cfg_data
);

    localparam int COORD_BITS = mep_pkg::COORD_BITS;

    mep_pkg::t_cfg    r_cfg;
    logic             fr_valid;
    logic             fr_ready;
    mep_pkg::t_point  fr_point;
    logic             bk_valid;
    logic             bk_ready;
    mep_pkg::t_point  bk_point;
    mep_pkg::t_rgb    rgb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.region_left <= mep_pkg::RST_REGION_LEFT;
            r_cfg.region_top <= mep_pkg::RST_REGION_TOP;
            r_cfg.step_real <= mep_pkg::RST_STEP_REAL;
            r_cfg.step_imag <= mep_pkg::RST_STEP_IMAG;
            r_cfg.iteration_limit <= mep_pkg::RST_ITER_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mep_pkg::CFG_REGION_LEFT: r_cfg.region_left <= i_cfg_data;
                mep_pkg::CFG_REGION_TOP:  r_cfg.region_top <= i_cfg_data;
                mep_pkg::CFG_STEP_REAL:   r_cfg.step_real <= i_cfg_data[mep_pkg::STEP_W-1:0];
                mep_pkg::CFG_STEP_IMAG:   r_cfg.step_imag <= i_cfg_data[mep_pkg::STEP_W-1:0];
                mep_pkg::CFG_ITER_LIMIT:  r_cfg.iteration_limit <= i_cfg_data[mep_pkg::LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    mep_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_pixel_x (s_axis_tdata[COORD_BITS-1:0]),
        .i_pixel_y (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .i_cfg     (r_cfg),
        .o_valid   (fr_valid),
        .i_ready   (fr_ready),
        .o_point   (fr_point)
    );

    mep_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .o_ready (fr_ready),
        .i_point (fr_point),
        .o_valid (bk_valid),
        .i_ready (bk_ready),
        .o_point (bk_point)
    );

    mep_iter #(
        .ITER_BITS     (ITER_BITS),
        .COLOR_DIVISOR (COLOR_DIVISOR)
    ) u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (bk_valid),
        .o_ready (bk_ready),
        .i_point (bk_point),
        .i_limit (r_cfg.iteration_limit),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_rgb   (rgb)
    );

    assign m_axis_tdata = rgb;

endmodule
